// ===== src/its_pkg.sv =====
// Shared types, constants and helpers for the INI token scanner.
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int FIELD_BITS  = 16;

  typedef logic [OFFSET_BITS-1:0] offs_t;
  typedef logic [FIELD_BITS-1:0]  field_t;
  typedef logic [1:0]             ev_kind_t;

  localparam ev_kind_t EV_NONE    = 2'd0;
  localparam ev_kind_t EV_SECTION = 2'd1;
  localparam ev_kind_t EV_KEY     = 2'd2;
  localparam ev_kind_t EV_VALUE   = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef enum logic [7:0] {
    ST_SEARCHING = 8'b0000_0001,
    ST_SECTION   = 8'b0000_0010,
    ST_KEY       = 8'b0000_0100,
    ST_AFTER_EQ  = 8'b0000_1000,
    ST_SEEK_VAL  = 8'b0001_0000,
    ST_VALUE     = 8'b0010_0000,
    ST_COMMENT   = 8'b0100_0000,
    ST_HALTED    = 8'b1000_0000
  } scan_state_t;

  function automatic offs_t sat_inc(input offs_t v);
    return (v == {OFFSET_BITS{1'b1}}) ? v : offs_t'(v + offs_t'(1));
  endfunction

  // Low field bits of an offset, zero-extended when the offset is narrower.
  function automatic field_t to_field(input offs_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== src/its_if.sv =====
// Channel interfaces: input byte stream and scan event stream.
`timescale 1ns / 1ps
`default_nettype none

interface its_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface its_out_if;
  logic                 valid;
  logic                 ready;
  its_pkg::ev_kind_t    event_kind;
  its_pkg::field_t      start_offset;
  its_pkg::field_t      end_offset;
  logic                 at_terminated;

  modport source (output valid, output event_kind, output start_offset,
                  output end_offset, output at_terminated, input ready);
  modport sink   (input valid, input event_kind, input start_offset,
                  input end_offset, input at_terminated, output ready);
endinterface

`default_nettype wire

// ===== src/ini_token_scanner_core.sv =====
// Top level: byte-serial INI scanner with a registered event output.
// An accepted byte's event appears on the output register in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is not stalled; the scan state update is a
// single pass of compare logic, and the output register takes a new event while the old is taken.
// Reset: synchronous, active low; state returns to searching with the scan offsets 0 and the
// output register empty. A byte with restart set clears the scan state in-band, then is scanned.
`timescale 1ns / 1ps
`default_nettype none

module ini_token_scanner_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  its_in_if.sink     in_chan,
  its_out_if.source  out_chan
);

  its_pkg::scan_state_t state_r, state_nxt, state_eff;
  logic                 at_mode_r, at_mode_nxt, at_mode_eff;
  its_pkg::offs_t       pos_r, pos_nxt, pos_eff;
  its_pkg::offs_t       sec_r, sec_nxt, sec_eff;
  its_pkg::offs_t       key_r, key_nxt, key_eff;

  its_pkg::ev_kind_t    kind_r, kind_nxt;
  its_pkg::offs_t       start_r, start_nxt;
  its_pkg::offs_t       end_r, end_nxt;
  logic                 at_r, at_nxt;
  logic                 out_valid_r;

  logic       in_fire;
  logic [7:0] c;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign c             = in_chan.data_byte;

  always_comb begin
    // restart clears the state before the same byte is scanned
    if (in_chan.restart) begin
      state_eff   = its_pkg::ST_SEARCHING;
      at_mode_eff = 1'b0;
      pos_eff     = '0;
      sec_eff     = '0;
      key_eff     = '0;
    end else begin
      state_eff   = state_r;
      at_mode_eff = at_mode_r;
      pos_eff     = pos_r;
      sec_eff     = sec_r;
      key_eff     = key_r;
    end

    state_nxt   = state_eff;
    at_mode_nxt = at_mode_eff;
    pos_nxt     = pos_eff;
    sec_nxt     = sec_eff;
    key_nxt     = key_eff;
    kind_nxt    = its_pkg::EV_NONE;
    start_nxt   = '0;
    end_nxt     = '0;
    at_nxt      = 1'b0;

    if (state_eff == its_pkg::ST_HALTED) begin
      state_nxt = its_pkg::ST_HALTED;
    end else if (c == its_pkg::CH_NUL) begin
      state_nxt = its_pkg::ST_HALTED;
    end else begin
      pos_nxt = its_pkg::sat_inc(pos_eff);
      unique case (state_eff)
        its_pkg::ST_SEARCHING: begin
          if (c == its_pkg::CH_LBRACK) begin
            state_nxt = its_pkg::ST_SECTION;
            sec_nxt   = its_pkg::sat_inc(pos_eff);
          end else if (c == its_pkg::CH_HASH) begin
            state_nxt = its_pkg::ST_COMMENT;
          end else if (!its_pkg::is_blank(c)) begin
            state_nxt = its_pkg::ST_KEY;
            key_nxt   = pos_eff;
          end
        end
        its_pkg::ST_SECTION: begin
          // tabs and spaces anywhere in the brackets push the name start forward
          if (c == its_pkg::CH_TAB || c == its_pkg::CH_SPACE) begin
            sec_nxt = its_pkg::sat_inc(sec_eff);
          end else if (c == its_pkg::CH_RBRACK) begin
            kind_nxt  = its_pkg::EV_SECTION;
            start_nxt = sec_eff;
            end_nxt   = pos_eff;
            state_nxt = its_pkg::ST_SEARCHING;
          end else if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end
        end
        its_pkg::ST_KEY: begin
          if (c == its_pkg::CH_EQUAL) begin
            kind_nxt  = its_pkg::EV_KEY;
            start_nxt = key_eff;
            end_nxt   = pos_eff;
            state_nxt = its_pkg::ST_AFTER_EQ;
          end else if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end
        end
        its_pkg::ST_AFTER_EQ: begin
          if (c == its_pkg::CH_AT) begin
            kind_nxt    = its_pkg::EV_VALUE;
            start_nxt   = its_pkg::sat_inc(pos_eff);
            at_nxt      = 1'b1;
            at_mode_nxt = 1'b1;
            state_nxt   = its_pkg::ST_VALUE;
          end else if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end else if (!its_pkg::is_blank(c)) begin
            kind_nxt    = its_pkg::EV_VALUE;
            start_nxt   = pos_eff;
            at_mode_nxt = 1'b0;
            state_nxt   = its_pkg::ST_VALUE;
          end else begin
            state_nxt = its_pkg::ST_SEEK_VAL;
          end
        end
        its_pkg::ST_SEEK_VAL: begin
          if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end else if (!its_pkg::is_blank(c)) begin
            kind_nxt    = its_pkg::EV_VALUE;
            start_nxt   = pos_eff;
            at_mode_nxt = 1'b0;
            state_nxt   = its_pkg::ST_VALUE;
          end
        end
        its_pkg::ST_VALUE: begin
          if (at_mode_eff) begin
            if (c == its_pkg::CH_AT) begin
              state_nxt   = its_pkg::ST_SEARCHING;
              at_mode_nxt = 1'b0;
            end
          end else if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end else if (c == its_pkg::CH_HASH) begin
            state_nxt = its_pkg::ST_COMMENT;
          end
        end
        its_pkg::ST_COMMENT: begin
          if (its_pkg::is_line_end(c)) begin
            state_nxt = its_pkg::ST_SEARCHING;
          end
        end
        default: begin
          state_nxt = its_pkg::ST_HALTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= its_pkg::ST_SEARCHING;
      at_mode_r   <= 1'b0;
      pos_r       <= '0;
      sec_r       <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r   <= state_nxt;
        at_mode_r <= at_mode_nxt;
        pos_r     <= pos_nxt;
        sec_r     <= sec_nxt;
        key_r     <= key_nxt;
      end
      out_valid_r <= in_fire || (out_valid_r && !out_chan.ready);
    end
  end

  // event payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= kind_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      at_r    <= at_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.event_kind    = kind_r;
  assign out_chan.start_offset  = its_pkg::to_field(start_r);
  assign out_chan.end_offset    = its_pkg::to_field(end_r);
  assign out_chan.at_terminated = at_r;

endmodule

`default_nettype wire

// ===== src/its_checker.sv =====
// Port-level checker for the INI token scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module its_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_restart,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire its_pkg::ev_kind_t out_event_kind,
  input wire its_pkg::field_t   out_start_offset,
  input wire its_pkg::field_t   out_end_offset,
  input wire logic              out_at_terminated
);

  // a stalled event transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind) &&
      $stable(out_start_offset) && $stable(out_end_offset) &&
      $stable(out_at_terminated))
    else $error("event payload changed while stalled");

  // an empty output stage always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

  // a restart byte scans from the searching state, which raises no event
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=>
      out_valid && out_event_kind == its_pkg::EV_NONE)
    else $error("restart byte produced an event");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == its_pkg::EV_NONE |->
      out_start_offset == '0 && out_end_offset == '0 && !out_at_terminated)
    else $error("no-event transaction carries nonzero fields");

  a_at_only_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_terminated |->
      out_event_kind == its_pkg::EV_VALUE && out_end_offset == '0)
    else $error("at_terminated set outside a value event");

endmodule

bind ini_token_scanner_core its_checker u_its_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_restart        (in_chan.restart),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_event_kind    (out_chan.event_kind),
  .out_start_offset  (out_chan.start_offset),
  .out_end_offset    (out_chan.end_offset),
  .out_at_terminated (out_chan.at_terminated)
);

`default_nettype wire
